// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cads_pkg.sv =====
// ----------------------------------------------------------------------------
// cads_pkg
// Types and constants of the clock alarm and drift supervisor.
// ----------------------------------------------------------------------------
package cads_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int DRIFT_W  = 8;
    localparam int DAYS_W   = 7;
    localparam int CFG_W    = 8;

    localparam int SECS_PER_MIN   = 60;
    localparam int MAX_MINSEC     = 59;
    localparam int MIN_HOUR_MINUTE = 3;

    typedef enum logic [2:0] {
        CFG_DRIFT_SECONDS,
        CFG_DAYS_PER_CORRECTION,
        CFG_ALARM_ENABLE,
        CFG_ALARM_HOUR,
        CFG_ALARM_MINUTE,
        CFG_NIGHT_ENABLE,
        CFG_NIGHT_START_HOUR,
        CFG_NIGHT_STOP_HOUR
    } t_cfg_idx;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic [SECOND_W-1:0] second_now;
        logic [DAY_W-1:0]    day_now;
    } t_cads_in;

    typedef struct packed {
        logic                time_write;
        logic [MINUTE_W-1:0] new_minute;
        logic [SECOND_W-1:0] new_second;
        logic                alarm_active;
        logic                alarm_started;
        logic                night_active;
    } t_cads_out;

endpackage

// ===== design/clock_alarm_drift_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// clock_alarm_drift_supervisor_unit
// Drift correction, alarm and night flags for one clock sample per item.
// ----------------------------------------------------------------------------
// Each input item is one clock sample (hour, minute, second, day) and gives
// exactly one result item with the corrected minute and second, the alarm
// flags and the night flag. Both channels use valid and stall; an item moves
// at a clock edge where valid is high and stall is low.
// An accepted item is held in the input register and is evaluated by the
// correction, alarm and night logic into the result register, from which
// the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall; the
// input register and the result register form a two-entry pipeline, so a
// new item is taken while a result waits. The input side stalls only when
// both registers are full and the receiver stalls.
// The configuration port writes one register per cycle when the write enable
// is high. The user must use it only while the block is idle; the block does
// not enforce this. A synchronous active-low reset clears the configuration,
// the day tracker, the day count and both flags, and empties the pipeline.
// ----------------------------------------------------------------------------
module clock_alarm_drift_supervisor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  cads_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [cads_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cads_pkg::t_cads_in            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cads_pkg::t_cads_out           o_out_data
);
    import cads_pkg::*;

    `include "assert_macros.svh"

    logic signed [DRIFT_W-1:0] r_drift;
    logic [DAYS_W-1:0]         r_days_per_corr;
    logic                      r_alarm_en;
    logic [HOUR_W-1:0]         r_alarm_hour;
    logic [MINUTE_W-1:0]       r_alarm_minute;
    logic                      r_night_en;
    logic [HOUR_W-1:0]         r_night_start;
    logic [HOUR_W-1:0]         r_night_stop;

    logic [DAY_W-1:0]          r_seen_day;
    logic [DAYS_W-1:0]         r_uncorr_days;
    logic                      r_alarm_flag;
    logic                      r_night_flag;

    logic [DAY_W-1:0]          n_seen_day;
    logic [DAYS_W-1:0]         n_uncorr_days;
    logic                      n_alarm_flag;
    logic                      n_night_flag;

    t_cads_in                  r_in;
    logic                      r_in_vld;
    t_cads_out                 r_out;
    logic                      r_out_vld;
    t_cads_out                 n_out;

    logic                      w_load;
    logic                      w_adv;

    logic signed [9:0]         w_sec_sum;
    logic signed [2:0]         w_carry;
    logic [SECOND_W-1:0]       w_sec_adj;
    logic signed [7:0]         w_min_raw;
    logic [MINUTE_W-1:0]       w_min_used;
    logic                      w_night;

    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign w_load     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift         <= '0;
            r_days_per_corr <= '0;
            r_alarm_en      <= 1'b0;
            r_alarm_hour    <= '0;
            r_alarm_minute  <= '0;
            r_night_en      <= 1'b0;
            r_night_start   <= '0;
            r_night_stop    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRIFT_SECONDS:       r_drift         <= i_cfg_data;
                CFG_DAYS_PER_CORRECTION: r_days_per_corr <= i_cfg_data[DAYS_W-1:0];
                CFG_ALARM_ENABLE:        r_alarm_en      <= i_cfg_data[0];
                CFG_ALARM_HOUR:          r_alarm_hour    <= i_cfg_data[HOUR_W-1:0];
                CFG_ALARM_MINUTE:        r_alarm_minute  <= i_cfg_data[MINUTE_W-1:0];
                CFG_NIGHT_ENABLE:        r_night_en      <= i_cfg_data[0];
                CFG_NIGHT_START_HOUR:    r_night_start   <= i_cfg_data[HOUR_W-1:0];
                CFG_NIGHT_STOP_HOUR:     r_night_stop    <= i_cfg_data[HOUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Adding the signed drift to the second and carrying whole minutes is the
    // same as shifting minute*60+second and splitting it again.
    always_comb begin
        w_sec_sum = $signed({4'b0, r_in.second_now}) + $signed({{2{r_drift[7]}}, r_drift});
        if (w_sec_sum >= 10'sd180) begin
            w_carry   = 3'sd3;
            w_sec_adj = SECOND_W'(w_sec_sum - 10'sd180);
        end else if (w_sec_sum >= 10'sd120) begin
            w_carry   = 3'sd2;
            w_sec_adj = SECOND_W'(w_sec_sum - 10'sd120);
        end else if (w_sec_sum >= 10'sd60) begin
            w_carry   = 3'sd1;
            w_sec_adj = SECOND_W'(w_sec_sum - 10'sd60);
        end else if (w_sec_sum >= 10'sd0) begin
            w_carry   = 3'sd0;
            w_sec_adj = SECOND_W'(w_sec_sum);
        end else if (w_sec_sum >= -10'sd60) begin
            w_carry   = -3'sd1;
            w_sec_adj = SECOND_W'(w_sec_sum + 10'sd60);
        end else if (w_sec_sum >= -10'sd120) begin
            w_carry   = -3'sd2;
            w_sec_adj = SECOND_W'(w_sec_sum + 10'sd120);
        end else begin
            w_carry   = -3'sd3;
            w_sec_adj = SECOND_W'(w_sec_sum + 10'sd180);
        end
        w_min_raw = $signed({2'b0, r_in.minute_now}) + $signed({{5{w_carry[2]}}, w_carry});
    end

    always_comb begin
        n_seen_day    = r_seen_day;
        n_uncorr_days = r_uncorr_days;
        n_alarm_flag  = r_alarm_flag;
        n_night_flag  = r_night_flag;
        n_out         = '0;
        w_min_used    = r_in.minute_now;
        w_night       = 1'b1;

        if (r_drift != '0) begin
            if (r_seen_day != r_in.day_now) begin
                n_uncorr_days = r_uncorr_days + DAYS_W'(1);
                n_seen_day    = r_in.day_now;
            end else if (r_uncorr_days == r_days_per_corr &&
                         r_in.hour_now >= HOUR_W'(MIN_HOUR_MINUTE) &&
                         r_in.minute_now >= MINUTE_W'(MIN_HOUR_MINUTE)) begin
                n_out.time_write = 1'b1;
                if (w_min_raw > 8'sd59) begin
                    n_out.new_minute = MINUTE_W'(MAX_MINSEC);
                    n_out.new_second = SECOND_W'(MAX_MINSEC);
                end else begin
                    n_out.new_minute = w_min_raw[MINUTE_W-1:0];
                    n_out.new_second = w_sec_adj;
                end
                w_min_used    = n_out.new_minute;
                n_uncorr_days = '0;
            end
        end

        if (r_alarm_en && r_in.hour_now == r_alarm_hour) begin
            if (w_min_used == r_alarm_minute) begin
                n_alarm_flag        = 1'b1;
                n_out.alarm_started = !r_alarm_flag;
            end else begin
                n_alarm_flag = 1'b0;
            end
        end

        if (r_night_start == r_night_stop) begin
            w_night = 1'b1;
        end else if (r_night_start > r_night_stop) begin
            w_night = !(r_in.hour_now > r_night_stop && r_in.hour_now <= r_night_start);
        end else begin
            w_night = r_in.hour_now >= r_night_start && r_in.hour_now < r_night_stop;
        end
        if (r_night_en) begin
            n_night_flag = w_night;
        end

        n_out.alarm_active = n_alarm_flag;
        n_out.night_active = n_night_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_seen_day    <= '0;
            r_uncorr_days <= '0;
            r_alarm_flag  <= 1'b0;
            r_night_flag  <= 1'b0;
        end else begin
            if (w_load) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld     <= 1'b1;
                r_seen_day    <= n_seen_day;
                r_uncorr_days <= n_uncorr_days;
                r_alarm_flag  <= n_alarm_flag;
                r_night_flag  <= n_night_flag;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    `ASSERT_IMPL(a_no_write_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.time_write,
        o_out_data.new_minute == '0 && o_out_data.new_second == '0,
        "Result without write carries a nonzero time.")

    `ASSERT_IMPL(a_write_in_range, i_clk, i_rst_n,
        o_out_valid && o_out_data.time_write,
        o_out_data.new_minute <= MINUTE_W'(MAX_MINSEC) &&
        o_out_data.new_second <= SECOND_W'(MAX_MINSEC),
        "Corrected time is beyond 59:59.")

    `ASSERT_IMPL(a_started_active, i_clk, i_rst_n,
        o_out_valid && o_out_data.alarm_started,
        o_out_data.alarm_active,
        "Alarm start reported without the alarm flag.")

    `ASSERT_NEXT(a_corr_clears_count, i_clk, i_rst_n,
        w_adv && n_out.time_write,
        r_uncorr_days == '0 && r_out_vld,
        "Correction did not clear the day count.")

endmodule
